### rtl/core/fmst_pkg.sv
// Shared types and codes for the max-search FIFO block.
// Used by fifo_with_max_search_and_trim and tb_top; depends on nothing.
`default_nettype none

package fmst_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned FILL_W        = 5;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_FIND = 2'd2,
    KIND_TRIM = 2'd3
  } fmst_kind_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } fmst_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fmst_state_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [FIELD_W-1:0]        tag_in;
    logic signed [FIELD_W-1:0] value_in;
  } fmst_in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [FIELD_W-1:0]        tag_out;
    logic signed [FIELD_W-1:0] value_out;
    logic [FILL_W-1:0]         fill_count;
  } fmst_out_t;

endpackage

`default_nettype wire

### rtl/core/fmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module fmst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/fifo_with_max_search_and_trim.sv
// Ring-buffer FIFO of (tag, value) entries with max search and trim.
// Uses fmst_pkg for item types and codes, and fmst_ram for entry storage.
//
// Usage: in_data carries a command (push, pop, find max, trim to max) on a
// valid/ready channel; every command yields exactly one item on out_data
// with status, reported tag/value and the fill count after the command.
// Push and pop: the result is registered and shown the cycle after
// acceptance. Find and trim read the held entries through the single RAM
// read port, one per cycle, and compare each read entry with the best so
// far; the result then goes to the output register.
// The block takes one command at a time; in_ready is high only while no
// scan runs and the output register is free or being drained.
// If the receiver holds out_ready low, the result stays in the output
// register and no new command is accepted until it is taken.
// Reset (rst_n low at a clock edge) empties the queue and drops any pending
// result; stored entries are not cleared, as only held entries are read.
`default_nettype none

module fifo_with_max_search_and_trim #(
  parameter int unsigned DEPTH = fmst_pkg::DEFAULT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fmst_pkg::fmst_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fmst_pkg::fmst_out_t     out_data
);

  import fmst_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = 2 * FIELD_W;

  // Control state
  fmst_state_t   state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] iss_off_r, iss_off_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;

  // Scan datapath
  logic                      trim_r, trim_nxt;
  logic [IW-1:0]             rd_slot_r, rd_slot_nxt;
  logic [CW-1:0]             cmp_off_r, cmp_off_nxt;
  logic [IW-1:0]             cmp_slot_r, cmp_slot_nxt;
  logic [CW-1:0]             best_off_r, best_off_nxt;
  logic [IW-1:0]             best_slot_r, best_slot_nxt;
  logic [FIELD_W-1:0]        best_tag_r, best_tag_nxt;
  logic signed [FIELD_W-1:0] best_val_r, best_val_nxt;
  fmst_out_t                 out_data_r, out_data_nxt;

  // RAM port
  logic          ram_wr_en;
  logic [EW-1:0] ram_wr_data;
  logic [EW-1:0] ram_rd_data;

  logic                      out_free;
  logic                      in_fire;
  logic [FIELD_W-1:0]        rd_tag;
  logic signed [FIELD_W-1:0] rd_val;
  logic [CW+FILL_W-1:0]      fill_ext;

  fmst_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data (ram_wr_data),
    .rd_addr (rd_slot_r),
    .rd_data (ram_rd_data)
  );

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] slot);
    ring_inc = (slot == IW'(DEPTH - 1)) ? '0 : slot + IW'(1);
  endfunction

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == ST_IDLE) && out_free;
  assign in_fire     = in_valid && in_ready;
  assign rd_tag      = ram_rd_data[EW-1:FIELD_W];
  assign rd_val      = $signed(ram_rd_data[FIELD_W-1:0]);
  assign ram_wr_data = {in_data.tag_in, in_data.value_in};
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    iss_off_nxt   = iss_off_r;
    cmp_vld_nxt   = 1'b0;
    trim_nxt      = trim_r;
    rd_slot_nxt   = rd_slot_r;
    cmp_off_nxt   = cmp_off_r;
    cmp_slot_nxt  = cmp_slot_r;
    best_off_nxt  = best_off_r;
    best_slot_nxt = best_slot_r;
    best_tag_nxt  = best_tag_r;
    best_val_nxt  = best_val_r;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    fill_ext      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_data_nxt.status    = STAT_DONE;
          out_data_nxt.tag_out   = '0;
          out_data_nxt.value_out = '0;
          unique case (fmst_kind_t'(in_data.kind))
            KIND_PUSH: begin
              if (cnt_r >= CW'(DEPTH)) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                ram_wr_en = 1'b1;
                tail_nxt  = ring_inc(tail_r);
                cnt_nxt   = cnt_r + CW'(1);
              end
              out_valid_nxt = 1'b1;
            end
            KIND_POP: begin
              if (cnt_r == '0) begin
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                head_nxt = ring_inc(head_r);
                cnt_nxt  = cnt_r - CW'(1);
              end
              out_valid_nxt = 1'b1;
            end
            KIND_FIND, KIND_TRIM: begin
              if (cnt_r == '0) begin
                out_data_nxt.status = STAT_EMPTY;
                out_valid_nxt       = 1'b1;
              end else begin
                // Start the scan at the head
                trim_nxt    = (fmst_kind_t'(in_data.kind) == KIND_TRIM);
                rd_slot_nxt = head_r;
                iss_off_nxt = '0;
                state_nxt   = ST_SCAN;
              end
            end
            default: ;
          endcase
          fill_ext                = {{FILL_W{1'b0}}, cnt_nxt};
          out_data_nxt.fill_count = fill_ext[FILL_W-1:0];
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle; its data is compared in the next cycle
        if (iss_off_r < cnt_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_off_nxt  = iss_off_r;
          cmp_slot_nxt = rd_slot_r;
          rd_slot_nxt  = ring_inc(rd_slot_r);
          iss_off_nxt  = iss_off_r + CW'(1);
        end
        if (cmp_vld_r) begin
          // Strictly greater keeps the earliest of equal maxima
          if (cmp_off_r == '0 || rd_val > best_val_r) begin
            best_off_nxt  = cmp_off_r;
            best_slot_nxt = cmp_slot_r;
            best_tag_nxt  = rd_tag;
            best_val_nxt  = rd_val;
          end
          if (cmp_off_r == cnt_r - CW'(1)) begin
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          if (trim_r) begin
            head_nxt = best_slot_r;
            cnt_nxt  = cnt_r - best_off_r;
          end
          out_data_nxt.status     = STAT_DONE;
          out_data_nxt.tag_out    = best_tag_r;
          out_data_nxt.value_out  = best_val_r;
          fill_ext                = {{FILL_W{1'b0}}, cnt_nxt};
          out_data_nxt.fill_count = fill_ext[FILL_W-1:0];
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      iss_off_r   <= '0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      iss_off_r   <= iss_off_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    trim_r      <= trim_nxt;
    rd_slot_r   <= rd_slot_nxt;
    cmp_off_r   <= cmp_off_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    best_off_r  <= best_off_nxt;
    best_slot_r <= best_slot_nxt;
    best_tag_r  <= best_tag_nxt;
    best_val_r  <= best_val_nxt;
    out_data_r  <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE))
    else $error("input ready while a scan is in progress");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (cmp_off_r < cnt_r) && (state_r == ST_SCAN))
    else $error("scan compares an entry beyond the held count");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (best_off_r < cnt_r))
    else $error("maximum offset beyond the held count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.kind == KIND_PUSH) && (cnt_r < CW'(DEPTH))
    |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("accepted push did not grow the queue");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking bench for fifo_with_max_search_and_trim: random push, pop, find-max and
// trim commands on a valid/ready channel, results checked against a shadow ring buffer.
// Depends on fmst_pkg and the RTL of the block only.

module tb_top;
  import fmst_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_DEPTH;
  localparam int unsigned N_RANDOM = 1600;

  typedef struct {
    fmst_in_t    cmd;
    int unsigned gap;
    bit          drain;
  } staged_cmd_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  fmst_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  fmst_out_t out_data;

  // shadow copy of the ring buffer
  logic [FIELD_W-1:0]        shadow_tag [DEPTH];
  logic signed [FIELD_W-1:0] shadow_val [DEPTH];
  int unsigned               shadow_head = 0;
  int unsigned               shadow_tail = 0;
  int unsigned               shadow_held = 0;

  staged_cmd_t cmd_q[$];
  fmst_out_t   fifo_replies[$];
  staged_cmd_t next_cmd;
  fmst_out_t   want;
  int unsigned n_staged = 0;
  int unsigned n_accepted = 0;
  int unsigned idle_cnt = 0;
  int unsigned n_errors = 0;
  int unsigned stall_left = 0;
  int unsigned rx_phase_left = 0;
  bit          rx_calm = 1'b0;

  fifo_with_max_search_and_trim #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #6000000;
    $display("tb_top failed");
    $finish;
  end

  // Apply one command to the shadow queue and return the reply it must give.
  function automatic fmst_out_t run_fifo_cmd(fmst_in_t c);
    fmst_out_t                 r;
    int unsigned               slot;
    int unsigned               best_off;
    int unsigned               k;
    logic signed [FIELD_W-1:0] best_val;
    r = '0;
    r.status = STAT_DONE;
    case (c.kind)
      KIND_PUSH: begin
        if (shadow_held == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_tag[shadow_tail] = c.tag_in;
          shadow_val[shadow_tail] = c.value_in;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_held++;
        end
      end
      KIND_POP: begin
        if (shadow_held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_held--;
        end
      end
      default: begin
        if (shadow_held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          best_off = 0;
          best_val = shadow_val[shadow_head];
          // strictly greater: the earliest of equal maxima wins
          for (k = 1; k < shadow_held; k++) begin
            slot = (shadow_head + k) % DEPTH;
            if (shadow_val[slot] > best_val) begin
              best_val = shadow_val[slot];
              best_off = k;
            end
          end
          slot = (shadow_head + best_off) % DEPTH;
          r.tag_out = shadow_tag[slot];
          r.value_out = shadow_val[slot];
          if (c.kind == KIND_TRIM) begin
            shadow_head = slot;
            shadow_held -= best_off;
          end
        end
      end
    endcase
    r.fill_count = shadow_held[FILL_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  // Often a narrow range, and sometimes the extremes, so that ties for the maximum are common.
  function automatic logic signed [FIELD_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 6) - 3;
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_tag();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic stage(fmst_kind_t kind, logic [FIELD_W-1:0] tag,
                       logic signed [FIELD_W-1:0] value, int unsigned gap, bit drain);
    staged_cmd_t s;
    s.cmd.kind = kind;
    s.cmd.tag_in = tag;
    s.cmd.value_in = value;
    s.gap = gap;
    s.drain = drain;
    cmd_q.push_back(s);
    n_staged++;
  endtask

  task automatic flag_error(string what, logic [127:0] exp_v, logic [127:0] got_v);
    n_errors++;
    if (n_errors <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
    end
  endtask

  // Driver: advance through cmd_q, hold the item until it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        fifo_replies.push_back(run_fifo_cmd(in_data));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_cnt < cmd_q[0].gap) begin
          idle_cnt <= idle_cnt + 1;
          in_valid <= 1'b0;
        end else if (cmd_q[0].drain && fifo_replies.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          next_cmd = cmd_q.pop_front();
          in_data <= next_cmd.cmd;
          in_valid <= 1'b1;
          idle_cnt <= 0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each item with the oldest reply.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 30) begin
        stall_left <= pick_idle();
      end
    end
    if (rx_phase_left == 0) begin
      rx_calm <= ($urandom_range(0, 3) == 0);
      rx_phase_left <= $urandom_range(100, 400);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (fifo_replies.size() == 0) begin
        flag_error("item with no command pending", '0, out_data);
      end else begin
        want = fifo_replies.pop_front();
        if (out_data.status !== want.status)
          flag_error("status", want.status, out_data.status);
        if (out_data.tag_out !== want.tag_out)
          flag_error("tag_out", want.tag_out, out_data.tag_out);
        if (out_data.value_out !== want.value_out)
          flag_error("value_out", want.value_out, out_data.value_out);
        if (out_data.fill_count !== want.fill_count)
          flag_error("fill_count", want.fill_count, out_data.fill_count);
      end
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned ep_len;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned r;
    int unsigned i;
    bit          calm;
    fmst_kind_t  kind;

    // empty queue, extremes, tie for maximum, trim with maximum at head
    stage(KIND_POP, '0, 0, 0, 1'b0);
    stage(KIND_FIND, '1, -1, 0, 1'b0);
    stage(KIND_TRIM, '1, -1, 0, 1'b0);
    stage(KIND_PUSH, '0, 32'sh8000_0000, 0, 1'b0);
    stage(KIND_PUSH, '1, 32'sh7fff_ffff, 0, 1'b0);
    stage(KIND_PUSH, 32'h5a5a_5a5a, 32'sh7fff_ffff, 0, 1'b0);
    stage(KIND_PUSH, 32'ha5a5_a5a5, -1, 0, 1'b0);
    stage(KIND_FIND, '0, 0, 0, 1'b0);
    stage(KIND_TRIM, '0, 0, 0, 1'b0);
    stage(KIND_TRIM, '0, 0, 0, 1'b0);
    stage(KIND_POP, '0, 0, 0, 1'b0);
    stage(KIND_FIND, '0, 0, 0, 1'b0);
    stage(KIND_POP, '0, 0, 0, 1'b0);
    stage(KIND_POP, '0, 0, 0, 1'b0);
    stage(KIND_POP, '0, 0, 0, 1'b0);
    stage(KIND_PUSH, 32'h0000_0001, 0, 0, 1'b0);
    stage(KIND_TRIM, '0, 0, 0, 1'b0);

    // Episodes that swing the fill level between empty and full.
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      ep_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: begin push_pct = 70; pop_pct = 10; end
        1: begin push_pct = 15; pop_pct = 55; end
        default: begin push_pct = 40; pop_pct = 20; end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < ep_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) kind = KIND_PUSH;
        else if (r < push_pct + pop_pct) kind = KIND_POP;
        else if (r[0]) kind = KIND_FIND;
        else kind = KIND_TRIM;
        stage(kind, pick_tag(), pick_value(), calm ? 0 : pick_idle(),
              (i == 0) && (n_rand == 0 || $urandom_range(0, 99) < 8));
        n_rand++;
      end
    end

    @(posedge clk);
    while (rst_n !== 1'b1 || n_accepted < n_staged || fifo_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DEPTH + 10) @(posedge clk);
    if (n_errors == 0 && fifo_replies.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
